/* rtl/core/wrm_pkg.sv */
// Shared constants and command/status types for the windowed RMS meter.
package wrm_pkg;

   // Default elaboration values for the top-level parameters.
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int MAX_WINDOW_DEF  = 1024;

   // Register file layout.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam int WIN_W      = 11;
   localparam int GAIN_W     = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 1'b1;

   localparam logic [WIN_W-1:0]  WINDOW_RESET = 11'd640;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 24'd7209;

   // Fixed-point scaling of the mean and of the gain product.
   localparam int MEAN_SHIFT = 8;
   localparam int GAIN_SHIFT = 16;

   // Result field widths.
   localparam int RMS_W    = 16;
   localparam int SCALED_W = 23;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic launch;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic mul_load;
   } wrm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic close_next;
   } wrm_sts_type;

endpackage

/* rtl/core/wrm_csr.sv */
// Configuration registers and effective window length for the RMS meter.
module wrm_csr #(
   parameter int MAX_WINDOW = wrm_pkg::MAX_WINDOW_DEF,
   parameter int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [wrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [CNT_W-1:0]               eff_window,
   output logic [wrm_pkg::GAIN_W-1:0]     gain
);
   import wrm_pkg::*;

   localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

   logic [WIN_W-1:0]  window_ff, window_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [CMP_W-1:0]  win_ext;
   logic [CMP_W-1:0]  max_ext;

   // Register write decode; unknown indexes are dropped.
   always_comb begin
      window_in = window_ff;
      gain_in   = gain_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW: window_in = csr_wdata[WIN_W-1:0];
            CSR_GAIN:   gain_in   = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         gain_ff   <= GAIN_RESET;
      end else begin
         window_ff <= window_in;
         gain_ff   <= gain_in;
      end
   end

   // A zero window acts as one sample; long windows saturate at the maximum.
   assign win_ext = CMP_W'(window_ff);
   assign max_ext = CMP_W'(MAX_WINDOW);

   always_comb begin
      if (window_ff == '0) begin
         eff_window = CNT_W'(1);
      end else if (win_ext > max_ext) begin
         eff_window = CNT_W'(MAX_WINDOW);
      end else begin
         eff_window = win_ext[CNT_W-1:0];
      end
   end

   assign gain = gain_ff;

endmodule

/* rtl/core/wrm_ctrl.sv */
// Sequencer for accumulation, divide, square root and gain multiply.
module wrm_ctrl #(
   parameter int SAMPLE_BITS = wrm_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wrm_pkg::MAX_WINDOW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  wrm_pkg::wrm_sts_type sts,
   output wrm_pkg::wrm_cmd_type cmd
);
   import wrm_pkg::*;

   localparam int SUM_W  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_WINDOW);
   localparam int Q_W    = SUM_W + MEAN_SHIFT;
   localparam int RT_W   = (Q_W + 1) / 2;
   localparam int STEP_W = $clog2(Q_W + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LAUNCH = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SQLD   = 3'd3;
   localparam logic [2:0] ST_SQRT   = 3'd4;
   localparam logic [2:0] ST_MUL    = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   // A beat that would close a window waits until the engine is free.
   assign req_stall = sts.close_next && (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);

   // Next state, step counter and datapath commands.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.accept    = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.close_next) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            cmd.launch = 1'b1;
            step_in    = STEP_W'(Q_W - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SQLD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SQLD: begin
            cmd.sqrt_load = 1'b1;
            step_in       = STEP_W'(RT_W - 1);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_MUL;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* rtl/core/wrm_dp.sv */
// Datapath: square and accumulate, restoring divider, root extractor, gain product.
module wrm_dp #(
   parameter int SAMPLE_BITS = wrm_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wrm_pkg::MAX_WINDOW_DEF,
   parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [CNT_W-1:0]             eff_window,
   input  logic [wrm_pkg::GAIN_W-1:0]   gain,
   input  wrm_pkg::wrm_cmd_type         cmd,
   output wrm_pkg::wrm_sts_type         sts,
   output logic [wrm_pkg::RMS_W-1:0]    rms_code_q4,
   output logic [wrm_pkg::SCALED_W-1:0] scaled_rms_q4
);
   import wrm_pkg::*;

   localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
   localparam int SUM_W  = SQ_W + $clog2(MAX_WINDOW);
   localparam int Q_W    = SUM_W + MEAN_SHIFT;
   localparam int RT_W   = (Q_W + 1) / 2;
   localparam int V_W    = 2 * RT_W;
   localparam int MP_W   = RT_W + GAIN_W;
   localparam int PROD_W = (MP_W > GAIN_SHIFT + SCALED_W) ? MP_W : GAIN_SHIFT + SCALED_W;

   // Accumulation side.
   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] sq_c;
   logic [SQ_W-1:0]          sq_ff;
   logic                     sq_vld_ff;
   logic [SUM_W-1:0]         sum_ff, sum_add;
   logic [CNT_W-1:0]         cnt_ff, cnt_plus;
   logic [CNT_W-1:0]         den_ff;

   // Divider.
   logic [Q_W-1:0]   num_ff, num_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W:0]   div_trial;
   logic             div_ge;

   // Root extractor.
   logic [V_W-1:0]  v_ff;
   logic [RT_W-1:0] srem_ff, srem_in;
   logic [RT_W-1:0] root_ff, root_in;
   logic [RT_W+1:0] sq_part;
   logic [RT_W+1:0] sq_trial;
   logic            sq_ge;

   // Gain product.
   logic [MP_W-1:0]   prod_c;
   logic [PROD_W-1:0] prod_ff;

   // Magnitude of the sample; the most negative code maps onto itself unsigned.
   assign mag  = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
   assign sq_c = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

   assign cnt_plus       = cnt_ff + 1'b1;
   assign sts.close_next = (cnt_plus >= eff_window);
   assign sum_add        = sum_ff + SUM_W'(sq_ff);

   // Square stage, then accumulate; the closing beat's square goes into the dividend.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         sum_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         sq_vld_ff <= cmd.accept;
         if (cmd.accept) begin
            if (sts.close_next) begin
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_plus;
            end
         end
         if (cmd.launch) begin
            sum_ff <= '0;
         end else if (sq_vld_ff) begin
            sum_ff <= sum_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sq_ff <= sq_c[SQ_W-1:0];
      end
      if (cmd.accept && sts.close_next) begin
         den_ff <= cnt_plus;
      end
   end

   // One quotient bit per step, shifted into the dividend register.
   assign div_trial = {rem_ff, num_ff[Q_W-1]};
   assign div_ge    = (div_trial >= {1'b0, den_ff});

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      if (cmd.launch) begin
         num_in = {sum_add, {MEAN_SHIFT{1'b0}}};
         rem_in = '0;
      end else if (cmd.div_step) begin
         num_in = {num_ff[Q_W-2:0], div_ge};
         rem_in = div_ge ? CNT_W'(div_trial - {1'b0, den_ff}) : CNT_W'(div_trial);
      end
   end

   // One root bit per step, consuming two bits of the mean.
   assign sq_part  = {srem_ff, v_ff[V_W-1 -: 2]};
   assign sq_trial = {root_ff, 2'b01};
   assign sq_ge    = (sq_part >= sq_trial);

   always_comb begin
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd.sqrt_load) begin
         srem_in = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         srem_in = sq_ge ? RT_W'(sq_part - sq_trial) : RT_W'(sq_part);
         root_in = {root_ff[RT_W-2:0], sq_ge};
      end
   end

   assign prod_c = MP_W'(root_ff) * MP_W'(gain);

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      if (cmd.sqrt_load) begin
         v_ff <= V_W'(num_ff);
      end else if (cmd.sqrt_step) begin
         v_ff <= {v_ff[V_W-3:0], 2'b00};
      end
      if (cmd.mul_load) begin
         prod_ff <= PROD_W'(prod_c);
      end
   end

   // Result fields hold while the result beat waits.
   assign rms_code_q4   = RMS_W'(root_ff);
   assign scaled_rms_q4 = prod_ff[GAIN_SHIFT +: SCALED_W];

endmodule

/* rtl/core/windowed_rms_meter.sv */
// Top level of the windowed true-RMS meter.
//
//   Channel | Direction | Ports                                     | Beat
//   req     | in        | req_valid, req_stall, req_sample          | one ADC sample
//   rsp     | out       | rsp_valid, rsp_stall, rsp_rms_code_q4,    | one RMS result
//           |           | rsp_scaled_rms_q4                         |
//   csr     | in        | csr_wr_en, csr_index, csr_wdata           | one register write
//
// Samples are taken one per clock while a window fills.
// The beat that closes a window starts the result engine: a launch step, a restoring divide
// over Q_W = 2*SAMPLE_BITS-1+clog2(MAX_WINDOW)+8 bits (41 by default) with one quotient bit
// per step, a load step, a root extraction of (Q_W+1)/2 bits (21 by default) and a multiply.
// The result is offered after the multiply; samples of the next window are taken while the
// engine runs, but the next window's closing beat stalls until the previous result is taken.
// Reset is synchronous and restores the registers to 640 and 7209 and empties the window.
module windowed_rms_meter #(
   parameter int SAMPLE_BITS = wrm_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wrm_pkg::MAX_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [wrm_pkg::RMS_W-1:0]      rsp_rms_code_q4,
   output logic [wrm_pkg::SCALED_W-1:0]   rsp_scaled_rms_q4,
   input  logic                           csr_wr_en,
   input  logic [wrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wrm_pkg::*;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   logic [CNT_W-1:0]  eff_window;
   logic [GAIN_W-1:0] gain;
   wrm_cmd_type       cmd;
   wrm_sts_type       sts;

   wrm_csr #(
      .MAX_WINDOW (MAX_WINDOW),
      .CNT_W      (CNT_W)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .eff_window (eff_window),
      .gain       (gain)
   );

   wrm_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wrm_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .CNT_W       (CNT_W)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .sample        (req_sample),
      .eff_window    (eff_window),
      .gain          (gain),
      .cmd           (cmd),
      .sts           (sts),
      .rms_code_q4   (rsp_rms_code_q4),
      .scaled_rms_q4 (rsp_scaled_rms_q4)
   );

   // A closing beat launches the result engine on the next cycle.
   a_close_launches: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.close_next) |=> cmd.launch)
      else $error("closing beat did not launch the engine");

   // The engine never launches while an earlier result is still offered.
   a_launch_not_out: assert property (@(posedge clock) disable iff (reset)
      cmd.launch |-> !rsp_valid)
      else $error("launch while a result beat is pending");

   // The engine runs one phase at a time.
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.launch, cmd.div_step, cmd.sqrt_load, cmd.sqrt_step, cmd.mul_load}))
      else $error("more than one engine phase active");

   // A result appears only right after the gain multiply or while it is held.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.mul_load))
      else $error("result beat without a finished multiply");

endmodule
